@@ rtl/cpp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cpp_pkg;

  // configuration register indexes
  localparam logic [3:0] CfgCamX    = 4'd0;
  localparam logic [3:0] CfgCamY    = 4'd1;
  localparam logic [3:0] CfgCamZ    = 4'd2;
  localparam logic [3:0] CfgCosYaw  = 4'd3;
  localparam logic [3:0] CfgSinYaw  = 4'd4;
  localparam logic [3:0] CfgCosTilt = 4'd5;
  localparam logic [3:0] CfgSinTilt = 4'd6;
  localparam logic [3:0] CfgFocal   = 4'd7;

  localparam int unsigned QuoBits = 17;
  localparam logic [QuoBits-1:0] QuoMaxPos = 17'd32767;
  localparam logic [QuoBits-1:0] QuoMaxNeg = 17'd32768;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic signed [15:0] cos_tilt;
    logic signed [15:0] sin_tilt;
    logic        [23:0] focal;
  } cfg_t;

  // front to back: numerators, positive denominator, behind flag
  typedef struct packed {
    logic signed [62:0] num_col;
    logic signed [62:0] num_row;
    logic        [43:0] den;
    logic               behind;
  } item_t;

  typedef struct packed {
    logic [61:0]        rem;
    logic [QuoBits-1:0] quo;
    logic               neg;
    logic               ovf;
  } lane_t;

  typedef struct packed {
    lane_t       col;
    lane_t       row;
    logic [43:0] den;
    logic        behind;
  } stage_t;

  typedef struct packed {
    logic signed [15:0] val;
    logic               sat;
  } coord_t;

  function automatic lane_t lane_init(logic signed [62:0] num, logic [43:0] den);
    lane_t r;
    logic [62:0] mag;
    mag = num[62] ? 63'(-num) : num;
    r.rem = mag[61:0];
    r.quo = '0;
    r.neg = num[62];
    r.ovf = (mag[61:0] >= {1'b0, den, 17'b0});
    return r;
  endfunction

  function automatic lane_t div_step(lane_t l, logic [43:0] den, int unsigned k);
    lane_t r;
    logic [61:0] trial;
    trial = {18'b0, den} << k;
    r = l;
    if (l.rem >= trial) begin
      r.rem = l.rem - trial;
      r.quo = l.quo | (17'(1) << k);
    end
    return r;
  endfunction

  function automatic coord_t clamp_lane(lane_t l);
    coord_t r;
    if (!l.neg) begin
      if (l.ovf || l.quo > QuoMaxPos) begin
        r.val = 16'sd32767;
        r.sat = 1'b1;
      end else begin
        r.val = l.quo[15:0];
        r.sat = 1'b0;
      end
    end else begin
      if (l.ovf || l.quo > QuoMaxNeg) begin
        r.val = -16'sd32768;
        r.sat = 1'b1;
      end else begin
        r.val = 16'(~l.quo + 17'd1);
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cpp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cpp_front #(
  parameter int unsigned IMG_WIDTH  = 640,
  parameter int unsigned IMG_HEIGHT = 480
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cpp_pkg::cfg_t      cfg_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  output      logic               push_o,
  output      cpp_pkg::item_t     item_o,
  input  wire logic               full_i
);

  localparam logic [12:0] HalfW = 13'(IMG_WIDTH / 2);
  localparam logic [12:0] HalfH = 13'(IMG_HEIGHT / 2);

  logic [7:1] vld_q;
  logic       en;

  logic signed [32:0] dx_q, dy_q, dz_q, dz2_q, dz3_q;
  logic signed [48:0] p_cx_q, p_sy_q, p_cy_q, p_sx_q;
  logic signed [35:0] fwd_q, lat_q, lat4_q, lat5_q;
  logic signed [51:0] t_cf_q, t_sz_q, t_cz_q, t_sf_q;
  logic signed [36:0] dep_q, ver_q;
  logic signed [60:0] lf_q;
  logic signed [61:0] vf_q;
  logic        [43:0] den_q, den7_q;
  logic               behind_q, behind7_q;
  logic signed [62:0] ncol_q, nrow_q;

  logic signed [49:0] fwd_sum, lat_sum;
  logic signed [52:0] dep_sum, ver_sum;
  logic        [56:0] cw, ch;

  assign en         = !(vld_q[7] && full_i);
  assign in_stall_o = !en;
  assign push_o     = vld_q[7] && !full_i;

  assign fwd_sum = 50'(p_cx_q) + 50'(p_sy_q);
  assign lat_sum = 50'(p_cy_q) - 50'(p_sx_q);
  assign dep_sum = 53'(t_cf_q) + 53'(t_sz_q);
  assign ver_sum = 53'(t_cz_q) - 53'(t_sf_q);
  assign cw      = 57'(den_q) * 57'(HalfW);
  assign ch      = 57'(den_q) * 57'(HalfH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[6:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q      <= 33'(point_x_i) - 33'(cfg_i.cam_x);
      dy_q      <= 33'(point_y_i) - 33'(cfg_i.cam_y);
      dz_q      <= 33'(point_z_i) - 33'(cfg_i.cam_z);
      // yaw rotation
      p_cx_q    <= 49'(cfg_i.cos_yaw) * 49'(dx_q);
      p_sy_q    <= 49'(cfg_i.sin_yaw) * 49'(dy_q);
      p_cy_q    <= 49'(cfg_i.cos_yaw) * 49'(dy_q);
      p_sx_q    <= 49'(cfg_i.sin_yaw) * 49'(dx_q);
      dz2_q     <= dz_q;
      fwd_q     <= 36'(fwd_sum >>> 14);
      lat_q     <= 36'(lat_sum >>> 14);
      dz3_q     <= dz2_q;
      // tilt rotation
      t_cf_q    <= 52'(cfg_i.cos_tilt) * 52'(fwd_q);
      t_sz_q    <= 52'(cfg_i.sin_tilt) * 52'(dz3_q);
      t_cz_q    <= 52'(cfg_i.cos_tilt) * 52'(dz3_q);
      t_sf_q    <= 52'(cfg_i.sin_tilt) * 52'(fwd_q);
      lat4_q    <= lat_q;
      dep_q     <= 37'(dep_sum >>> 14);
      ver_q     <= 37'(ver_sum >>> 14);
      lat5_q    <= lat4_q;
      // projection numerators
      lf_q      <= 61'(lat5_q) * $signed({37'b0, cfg_i.focal});
      vf_q      <= 62'(ver_q) * $signed({38'b0, cfg_i.focal});
      den_q     <= {dep_q[35:0], 8'b0};
      behind_q  <= (dep_q <= 37'sd0);
      ncol_q    <= $signed({6'b0, cw}) + 63'(lf_q);
      nrow_q    <= $signed({6'b0, ch}) - 63'(vf_q);
      den7_q    <= den_q;
      behind7_q <= behind_q;
    end
  end

  assign item_o.num_col = ncol_q;
  assign item_o.num_row = nrow_q;
  assign item_o.den     = den7_q;
  assign item_o.behind  = behind7_q;

endmodule
`default_nettype wire

@@ rtl/cpp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cpp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cpp_pkg::item_t item_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      logic           empty_o,
  output      cpp_pkg::item_t item_o
);

  cpp_pkg::item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

@@ rtl/cpp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cpp_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire cpp_pkg::item_t     item_i,
  output      logic               pop_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [15:0] pixel_col_o,
  output      logic signed [15:0] pixel_row_o,
  output      logic               behind_camera_o,
  output      logic               saturated_o
);

  localparam int unsigned Steps = cpp_pkg::QuoBits;

  cpp_pkg::stage_t stg_q [Steps+1];
  logic [Steps:0]  vld_q;
  logic            en;
  cpp_pkg::coord_t col_c, row_c;

  assign en    = !(out_valid_o && out_stall_i);
  assign pop_o = !empty_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[Steps-1:0], !empty_i};
      out_valid_o <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q[0].col    <= cpp_pkg::lane_init(item_i.num_col, item_i.den);
      stg_q[0].row    <= cpp_pkg::lane_init(item_i.num_row, item_i.den);
      stg_q[0].den    <= item_i.den;
      stg_q[0].behind <= item_i.behind;
      // one quotient bit per stage, msb first
      for (int s = 1; s <= Steps; s++) begin
        stg_q[s].col    <= cpp_pkg::div_step(stg_q[s-1].col, stg_q[s-1].den,
                                             Steps - unsigned'(s));
        stg_q[s].row    <= cpp_pkg::div_step(stg_q[s-1].row, stg_q[s-1].den,
                                             Steps - unsigned'(s));
        stg_q[s].den    <= stg_q[s-1].den;
        stg_q[s].behind <= stg_q[s-1].behind;
      end
    end
  end

  assign col_c = cpp_pkg::clamp_lane(stg_q[Steps].col);
  assign row_c = cpp_pkg::clamp_lane(stg_q[Steps].row);

  always_ff @(posedge clk_i) begin
    if (en) begin
      behind_camera_o <= stg_q[Steps].behind;
      pixel_col_o     <= stg_q[Steps].behind ? 16'sd0 : col_c.val;
      pixel_row_o     <= stg_q[Steps].behind ? 16'sd0 : row_c.val;
      saturated_o     <= !stg_q[Steps].behind && (col_c.sat || row_c.sat);
    end
  end

endmodule
`default_nettype wire

@@ rtl/camera_point_projection.sv @@
//  channel | direction | handshake               | payload
//  cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//  in      | in        | in_valid_i / in_stall_o  | point_x_i, point_y_i, point_z_i
//  out     | out       | out_valid_o / out_stall_i| pixel_col_o, pixel_row_o, flags
//
//  one point per cycle sustained while out_stall_i stays low; the rotation
//  front, the two-entry queue and the division back end follow in turn
//  (one quotient bit per stage for 17 bits, plus setup and clamp stages)
//  reset clears all valids and loads the default camera; no clearing pass
//  front and back stall independently, the queue absorbs the difference
`timescale 1ns / 1ps
`default_nettype none
module camera_point_projection #(
  parameter int unsigned IMG_WIDTH  = 640,
  parameter int unsigned IMG_HEIGHT = 480
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [3:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [15:0] pixel_col_o,
  output      logic signed [15:0] pixel_row_o,
  output      logic               behind_camera_o,
  output      logic               saturated_o
);

  cpp_pkg::cfg_t  cfg_q;
  cpp_pkg::item_t f_item, q_item;
  logic           push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_x    <= '0;
      cfg_q.cam_y    <= '0;
      cfg_q.cam_z    <= '0;
      cfg_q.cos_yaw  <= 16'sd16384;
      cfg_q.sin_yaw  <= '0;
      cfg_q.cos_tilt <= 16'sd16384;
      cfg_q.sin_tilt <= '0;
      cfg_q.focal    <= 24'd153600;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cpp_pkg::CfgCamX:    cfg_q.cam_x    <= cfg_data_i;
        cpp_pkg::CfgCamY:    cfg_q.cam_y    <= cfg_data_i;
        cpp_pkg::CfgCamZ:    cfg_q.cam_z    <= cfg_data_i;
        cpp_pkg::CfgCosYaw:  cfg_q.cos_yaw  <= cfg_data_i[15:0];
        cpp_pkg::CfgSinYaw:  cfg_q.sin_yaw  <= cfg_data_i[15:0];
        cpp_pkg::CfgCosTilt: cfg_q.cos_tilt <= cfg_data_i[15:0];
        cpp_pkg::CfgSinTilt: cfg_q.sin_tilt <= cfg_data_i[15:0];
        cpp_pkg::CfgFocal:   cfg_q.focal    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  cpp_front #(
    .IMG_WIDTH (IMG_WIDTH),
    .IMG_HEIGHT(IMG_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .push_o    (push),
    .item_o    (f_item),
    .full_i    (full)
  );

  cpp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (q_item)
  );

  cpp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .item_i         (q_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_col_o    (pixel_col_o),
    .pixel_row_o    (pixel_row_o),
    .behind_camera_o(behind_camera_o),
    .saturated_o    (saturated_o)
  );

endmodule
`default_nettype wire
